>>> rtl/texture_resample_pixel_pack_defines.svh
// assertion helpers for the texture resample pixel pack block
`ifndef TEXTURE_RESAMPLE_PIXEL_PACK_DEFINES_SVH
`define TEXTURE_RESAMPLE_PIXEL_PACK_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TRPP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trpp check failed");

// next-cycle implication, checked on every rising edge outside reset
`define TRPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trpp check failed");

`endif

>>> rtl/trpp_pkg.sv
`timescale 1ns / 1ps

package trpp_pkg;

  localparam int SOURCE_SIDE = 256;
  localparam int SIDE_W      = $clog2(SOURCE_SIDE);
  localparam int COORD_W     = 8;
  localparam int DIV_RAW_W   = COORD_W + 2 * SIDE_W;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_STAGES  = (DIV_RAW_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W       = DIV_STAGES * DIV_STEPS;
  localparam int SUM_W       = DIV_W + 1;
  localparam int PAGE_W      = 9;
  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 3;

  localparam logic FUNC_ADDRESS = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  localparam logic [1:0] FMT_PACK   = 2'd0;
  localparam logic [1:0] FMT_COPY32 = 2'd1;
  localparam logic [1:0] FMT_COPY16 = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_BITS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SHIFTS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES    = 3'd5;

  typedef enum logic [1:0] {
    KIND_INDEX = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_WORD  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [2:0]          count;
    logic [31:0]         word;
    logic [DIV_W-1:0]    acc_x;
    logic [DIV_W-1:0]    acc_y;
    logic [PAGE_W-1:0]   rem_x;
    logic [PAGE_W-1:0]   rem_y;
  } item_t;

  function automatic logic [31:0] pack_channel(input logic [7:0] value,
                                               input logic [3:0] bits,
                                               input logic [4:0] shift);
    logic [3:0] keep;
    logic [7:0] kept;
    keep = (bits > 4'd8) ? 4'd8 : bits;
    kept = value >> (4'd8 - keep);
    return 32'(kept) << shift;
  endfunction

endpackage

>>> rtl/texture_resample_pixel_pack.sv
`timescale 1ns / 1ps

// Texture upload converter. Address requests and pass-through texels give one result word
// each; a packed pixel holds the byte-wide result serializer for one beat per byte, with
// pixel_bytes clamped to 1 to 4, and busy rises when that serializer backs up into a full
// pipeline. Accepted items pass the entry register, the DIV_STAGES stages of a pipelined
// restoring divider that retires four quotient bits per stage, and the serializer register.
// Results cannot be held off: done marks each result beat for exactly one cycle.
module texture_resample_pixel_pack (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           func,
  input  logic [7:0]                     dest_x,
  input  logic [7:0]                     dest_y,
  input  logic [31:0]                    texel,
  output logic                           done,
  output logic [1:0]                     kind,
  output logic [31:0]                    data,
  output logic                           last,
  input  logic                           cfg_write,
  input  logic [trpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trpp_pkg::CFG_W-1:0]     cfg_data
);

  localparam int NS = trpp_pkg::DIV_STAGES;

  logic [trpp_pkg::PAGE_W-1:0] page_width;
  logic [trpp_pkg::PAGE_W-1:0] page_height;
  logic [1:0]                  source_format;
  logic [15:0]                 channel_bits;
  logic [19:0]                 channel_shifts;
  logic [2:0]                  pixel_bytes;

  logic [trpp_pkg::PAGE_W-1:0] div_w;
  logic [trpp_pkg::PAGE_W-1:0] div_h;
  logic [2:0]                  byte_count;

  trpp_pkg::item_t entry;
  trpp_pkg::item_t stg [0:NS];
  trpp_pkg::item_t nxt [0:NS-1];
  logic            vld [0:NS];
  logic            rdy [0:NS];

  logic                        ser_valid;
  logic [2:0]                  ser_left;
  trpp_pkg::kind_t             ser_kind;
  logic [31:0]                 ser_word;
  logic                        ser_free;
  logic [trpp_pkg::SUM_W-1:0]  index_sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_width     <= 9'd256;
      page_height    <= 9'd256;
      source_format  <= trpp_pkg::FMT_PACK;
      channel_bits   <= 16'h8888;
      channel_shifts <= 20'h0;
      pixel_bytes    <= 3'd4;
    end else if (cfg_write) begin
      unique case (cfg_index)
        trpp_pkg::REG_PAGE_WIDTH:     page_width     <= cfg_data[8:0];
        trpp_pkg::REG_PAGE_HEIGHT:    page_height    <= cfg_data[8:0];
        trpp_pkg::REG_SOURCE_FORMAT:  source_format  <= cfg_data[1:0];
        trpp_pkg::REG_CHANNEL_BITS:   channel_bits   <= cfg_data[15:0];
        trpp_pkg::REG_CHANNEL_SHIFTS: channel_shifts <= cfg_data[19:0];
        trpp_pkg::REG_PIXEL_BYTES:    pixel_bytes    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign div_w = (page_width == '0) ? trpp_pkg::PAGE_W'(1) : page_width;
  assign div_h = (page_height == '0) ? trpp_pkg::PAGE_W'(1) : page_height;
  assign byte_count = (pixel_bytes == 3'd0) ? 3'd1 :
                      (pixel_bytes > 3'd4)  ? 3'd4 : pixel_bytes;

  // entry decode and channel packing
  always_comb begin
    entry       = '0;
    entry.acc_x = trpp_pkg::DIV_W'(dest_x) * trpp_pkg::DIV_W'(trpp_pkg::SOURCE_SIDE);
    entry.acc_y = trpp_pkg::DIV_W'(dest_y)
                * trpp_pkg::DIV_W'(trpp_pkg::SOURCE_SIDE * trpp_pkg::SOURCE_SIDE);
    if (func == trpp_pkg::FUNC_ADDRESS) begin
      entry.kind  = trpp_pkg::KIND_INDEX;
      entry.count = 3'd1;
    end else begin
      case (source_format)
        trpp_pkg::FMT_PACK: begin
          entry.kind  = trpp_pkg::KIND_BYTE;
          entry.count = byte_count;
          entry.word  = trpp_pkg::pack_channel(texel[23:16], channel_bits[3:0],
                                               channel_shifts[4:0])
                      | trpp_pkg::pack_channel(texel[15:8], channel_bits[7:4],
                                               channel_shifts[9:5])
                      | trpp_pkg::pack_channel(texel[7:0], channel_bits[11:8],
                                               channel_shifts[14:10])
                      | trpp_pkg::pack_channel(texel[31:24], channel_bits[15:12],
                                               channel_shifts[19:15]);
        end
        trpp_pkg::FMT_COPY32: begin
          entry.kind  = trpp_pkg::KIND_WORD;
          entry.count = 3'd1;
          entry.word  = texel;
        end
        trpp_pkg::FMT_COPY16: begin
          entry.kind  = trpp_pkg::KIND_WORD;
          entry.count = 3'd1;
          entry.word  = {16'h0, texel[15:0]};
        end
        default: begin
          entry.kind  = trpp_pkg::KIND_WORD;
          entry.count = 3'd0;
        end
      endcase
    end
  end

  // restoring division, four quotient bits per stage for both terms
  always_comb begin : div_steps
    logic [trpp_pkg::PAGE_W:0] tx;
    logic [trpp_pkg::PAGE_W:0] ty;
    for (int s = 0; s < NS; s++) begin
      nxt[s] = stg[s];
      for (int i = 0; i < trpp_pkg::DIV_STEPS; i++) begin
        tx = {nxt[s].rem_x, nxt[s].acc_x[trpp_pkg::DIV_W-1]};
        ty = {nxt[s].rem_y, nxt[s].acc_y[trpp_pkg::DIV_W-1]};
        nxt[s].acc_x = nxt[s].acc_x << 1;
        nxt[s].acc_y = nxt[s].acc_y << 1;
        if (tx >= {1'b0, div_w}) begin
          tx = tx - {1'b0, div_w};
          nxt[s].acc_x[0] = 1'b1;
        end
        if (ty >= {1'b0, div_h}) begin
          ty = ty - {1'b0, div_h};
          nxt[s].acc_y[0] = 1'b1;
        end
        nxt[s].rem_x = tx[trpp_pkg::PAGE_W-1:0];
        nxt[s].rem_y = ty[trpp_pkg::PAGE_W-1:0];
      end
    end
  end

  // per-stage ready, bubbles collapse under a stall
  assign ser_free = !ser_valid || (ser_left == 3'd1);

  always_comb begin
    rdy[NS] = !vld[NS] || ser_free;
    for (int s = NS - 1; s >= 0; s--) begin
      rdy[s] = !vld[s] || rdy[s+1];
    end
  end

  assign busy = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= NS; s++) begin
        vld[s] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        vld[0] <= start;
      end
      for (int s = 1; s <= NS; s++) begin
        if (rdy[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      stg[0] <= entry;
    end
    for (int s = 1; s <= NS; s++) begin
      if (rdy[s]) begin
        stg[s] <= nxt[s-1];
      end
    end
  end

  // output serializer, one beat per cycle
  assign index_sum = trpp_pkg::SUM_W'(stg[NS].acc_x) + trpp_pkg::SUM_W'(stg[NS].acc_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_left  <= 3'd0;
    end else if (ser_free) begin
      ser_valid <= vld[NS] && (stg[NS].count != 3'd0);
      ser_left  <= stg[NS].count;
    end else begin
      ser_left  <= ser_left - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_free) begin
      ser_kind <= stg[NS].kind;
      ser_word <= (stg[NS].kind == trpp_pkg::KIND_INDEX) ? 32'(index_sum) : stg[NS].word;
    end else begin
      ser_word <= ser_word >> 8;
    end
  end

  assign done = ser_valid;
  assign kind = ser_kind;
  assign data = (ser_kind == trpp_pkg::KIND_BYTE) ? {24'h0, ser_word[7:0]} : ser_word;
  assign last = (ser_left == 3'd1);

endmodule

>>> rtl/trpp_port_check.sv
`timescale 1ns / 1ps
`include "texture_resample_pixel_pack_defines.svh"

module trpp_port_check (
  input logic        clk,
  input logic        rst,
  input logic        done,
  input logic [1:0]  kind,
  input logic [31:0] data,
  input logic        last
);

  // a pixel's bytes go out without gaps
  `TRPP_ASSERT_NEXT(a_burst_continues, done && !last, done)
  // only packed pixels span several beats
  `TRPP_ASSERT_NOW(a_multi_is_byte, done && !last, kind == trpp_pkg::KIND_BYTE)
  // beats of one pixel keep their kind
  `TRPP_ASSERT_NEXT(a_burst_kind, done && !last, kind == $past(kind))
  // a packed beat carries one byte
  `TRPP_ASSERT_NOW(a_byte_width, done && kind == trpp_pkg::KIND_BYTE, data[31:8] == 24'h0)

endmodule

bind texture_resample_pixel_pack trpp_port_check u_port_check (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import trpp_pkg::*;

  localparam int LIMIT = 300000;
  localparam int DRAIN = 24;
  localparam logic [1:0] FMT_UNUSED = 2'd3;

  typedef struct {
    logic        f;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [31:0] t;
  } request_t;

  typedef struct {
    kind_t       kind;
    logic [31:0] data;
    logic        last;
  } beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 func = 1'b0;
  logic [7:0]           dest_x = '0;
  logic [7:0]           dest_y = '0;
  logic [31:0]          texel = '0;
  logic                 done;
  logic [1:0]           kind;
  logic [31:0]          data;
  logic                 last;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // shadow copy of the configuration registers
  logic [8:0]  page_width = 9'd256;
  logic [8:0]  page_height = 9'd256;
  logic [1:0]  src_format = FMT_PACK;
  logic [15:0] keep_bits = 16'h8888;
  logic [19:0] positions = '0;
  logic [2:0]  byte_count = 3'd4;

  request_t    requests[$];
  beat_t       due_beats[$];
  int unsigned gap_left = 0;
  bit          gaps_on = 1'b1;
  int          errors = 0;
  int          cycles = 0;

  texture_resample_pixel_pack dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .dest_x(dest_x), .dest_y(dest_y), .texel(texel), .done(done),
    .kind(kind), .data(data), .last(last), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] source_index(logic [7:0] x, logic [7:0] y);
    longint unsigned w, h, xl, yl, side;
    w = (page_width == 0) ? 64'd1 : 64'(page_width);
    h = (page_height == 0) ? 64'd1 : 64'(page_height);
    xl = 64'(x);
    yl = 64'(y);
    side = 64'(SOURCE_SIDE);
    return 32'(xl * side / w + yl * side * side / h);
  endfunction

  function automatic logic [31:0] trim_channel(logic [7:0] v, logic [3:0] n, logic [4:0] sh);
    logic [3:0]  k;
    logic [31:0] kept;
    k = (n > 4'd8) ? 4'd8 : n;
    kept = {24'b0, v} >> (4'd8 - k);
    return kept << sh;
  endfunction

  function automatic void queue_outputs(logic f, logic [7:0] x, logic [7:0] y,
                                        logic [31:0] t);
    beat_t       b;
    logic [31:0] word;
    int          n;
    if (f == FUNC_ADDRESS) begin
      b = '{KIND_INDEX, source_index(x, y), 1'b1};
      due_beats.push_back(b);
      return;
    end
    case (src_format)
      FMT_COPY32: begin
        b = '{KIND_WORD, t, 1'b1};
        due_beats.push_back(b);
      end
      FMT_COPY16: begin
        b = '{KIND_WORD, {16'b0, t[15:0]}, 1'b1};
        due_beats.push_back(b);
      end
      FMT_PACK: begin
        word = trim_channel(t[23:16], keep_bits[3:0], positions[4:0])
             | trim_channel(t[15:8], keep_bits[7:4], positions[9:5])
             | trim_channel(t[7:0], keep_bits[11:8], positions[14:10])
             | trim_channel(t[31:24], keep_bits[15:12], positions[19:15]);
        n = (byte_count == 3'd0) ? 1 : (byte_count > 3'd4) ? 4 : int'(byte_count);
        for (int k = 0; k < n; k++) begin
          b = '{KIND_BYTE, {24'b0, word[7:0]}, k == n - 1};
          due_beats.push_back(b);
          word = word >> 8;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    case (idx)
      REG_PAGE_WIDTH:     page_width = v[8:0];
      REG_PAGE_HEIGHT:    page_height = v[8:0];
      REG_SOURCE_FORMAT:  src_format = v[1:0];
      REG_CHANNEL_BITS:   keep_bits = v[15:0];
      REG_CHANNEL_SHIFTS: positions = v[19:0];
      REG_PIXEL_BYTES:    byte_count = v[2:0];
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // driver and shadow register update
  always @(posedge clk) begin
    if (cfg_write) apply_reg(cfg_index, cfg_data);
    if (!rst) begin
      if (start && !busy) queue_outputs(func, dest_x, dest_y, texel);
      if (!start || !busy) begin
        if (gaps_on && gap_left != 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (requests.size() != 0) begin
          request_t r;
          r = requests.pop_front();
          func <= r.f;
          dest_x <= r.x;
          dest_y <= r.y;
          texel <= r.t;
          start <= 1'b1;
          gap_left = gaps_on ? pick_gap() : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    beat_t got, want;
    if (!rst && done) begin
      got = '{kind_t'(kind), data, last};
      if (due_beats.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: kind %0d data %h last %0d", got.kind, got.data, got.last);
      end else begin
        want = due_beats.pop_front();
        if (got.kind !== want.kind || got.data !== want.data || got.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: kind exp %0d got %0d, data exp %h got %h, last exp %0d got %0d",
                     want.kind, got.kind, want.data, got.data, want.last, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic add(logic f, logic [7:0] x, logic [7:0] y, logic [31:0] t);
    request_t r;
    r = '{f, x, y, t};
    requests.push_back(r);
  endtask

  task automatic settle();
    @(negedge clk);
    while (requests.size() != 0 || start || due_beats.size() != 0) @(negedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [8:0] pick_page();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return 9'd0;
    if (r < 8) return 9'($urandom_range(257, 511));
    if (r < 14) return 9'd1;
    if (r < 20) return 9'd256;
    return 9'($urandom_range(1, 256));
  endfunction

  task automatic random_setup();
    logic [15:0] b;
    logic [1:0]  fmt;
    logic [2:0]  nb;
    b = '0;
    for (int i = 0; i < 4; i++)
      b[i*4 +: 4] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8));
    case ($urandom_range(0, 9))
      0:       fmt = FMT_UNUSED;
      1, 2:    fmt = FMT_COPY32;
      3, 4:    fmt = FMT_COPY16;
      default: fmt = FMT_PACK;
    endcase
    nb = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    write_reg(REG_PAGE_WIDTH, CFG_W'(pick_page()));
    write_reg(REG_PAGE_HEIGHT, CFG_W'(pick_page()));
    write_reg(REG_SOURCE_FORMAT, CFG_W'(fmt));
    write_reg(REG_CHANNEL_BITS, CFG_W'(b));
    write_reg(REG_CHANNEL_SHIFTS, CFG_W'($urandom));
    write_reg(REG_PIXEL_BYTES, CFG_W'(nb));
  endtask

  function automatic logic [7:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_items(int n);
    logic [31:0] t;
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 15))
        0:       t = 32'h0;
        1:       t = 32'hffff_ffff;
        default: t = $urandom;
      endcase
      add($urandom_range(0, 1) ? FUNC_CONVERT : FUNC_ADDRESS, pick_coord(), pick_coord(), t);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration
    @(negedge clk);
    add(FUNC_ADDRESS, 8'h00, 8'h00, 32'h0);
    add(FUNC_ADDRESS, 8'hff, 8'hff, 32'h0);
    add(FUNC_ADDRESS, 8'hff, 8'h00, 32'hffff_ffff);
    add(FUNC_ADDRESS, 8'h00, 8'hff, 32'h0);
    add(FUNC_CONVERT, 8'h00, 8'h00, 32'h0000_0000);
    add(FUNC_CONVERT, 8'hff, 8'hff, 32'hffff_ffff);
    add(FUNC_CONVERT, 8'h00, 8'h00, 32'h1234_5678);
    settle();

    // zero divisors, oversized kept bits, shifts past bit 31, zero byte count
    write_reg(REG_PAGE_WIDTH, CFG_W'(9'd0));
    write_reg(REG_PAGE_HEIGHT, CFG_W'(9'd0));
    write_reg(REG_CHANNEL_BITS, CFG_W'(16'hffff));
    write_reg(REG_CHANNEL_SHIFTS, 20'hfffff);
    write_reg(REG_PIXEL_BYTES, CFG_W'(3'd0));
    @(negedge clk);
    add(FUNC_ADDRESS, 8'hff, 8'hff, 32'h0);
    add(FUNC_ADDRESS, 8'h01, 8'h01, 32'h0);
    add(FUNC_CONVERT, 8'h00, 8'h00, 32'ha5a5_a5a5);
    settle();

    // unused format: converts give nothing, addresses still answer
    write_reg(REG_SOURCE_FORMAT, CFG_W'(FMT_UNUSED));
    @(negedge clk);
    add(FUNC_CONVERT, 8'h00, 8'h00, 32'hffff_ffff);
    add(FUNC_ADDRESS, 8'h07, 8'h09, 32'h0);
    settle();

    write_reg(REG_PAGE_WIDTH, CFG_W'(9'd511));
    write_reg(REG_PAGE_HEIGHT, CFG_W'(9'd1));
    write_reg(REG_SOURCE_FORMAT, CFG_W'(FMT_COPY16));
    write_reg(REG_PIXEL_BYTES, CFG_W'(3'd7));
    @(negedge clk);
    add(FUNC_ADDRESS, 8'hff, 8'hff, 32'h0);
    add(FUNC_CONVERT, 8'h00, 8'h00, 32'hffff_1234);
    settle();
    write_reg(REG_SOURCE_FORMAT, CFG_W'(FMT_PACK));
    @(negedge clk);
    add(FUNC_CONVERT, 8'h00, 8'h00, 32'hdead_beef);
    settle();

    write_reg(REG_PAGE_WIDTH, CFG_W'(9'd1));
    write_reg(REG_PAGE_HEIGHT, CFG_W'(9'd511));
    write_reg(REG_SOURCE_FORMAT, CFG_W'(FMT_COPY32));
    @(negedge clk);
    add(FUNC_CONVERT, 8'h00, 8'h00, 32'hffff_ffff);
    add(FUNC_CONVERT, 8'h00, 8'h00, 32'h8000_0001);
    add(FUNC_ADDRESS, 8'h80, 8'h40, 32'h0);
    settle();

    // zero kept bits, then 7, 5, 3 and 1 kept bits at byte-aligned shifts
    write_reg(REG_SOURCE_FORMAT, CFG_W'(FMT_PACK));
    write_reg(REG_CHANNEL_BITS, CFG_W'(16'h0000));
    write_reg(REG_CHANNEL_SHIFTS, 20'h0);
    write_reg(REG_PIXEL_BYTES, CFG_W'(3'd3));
    @(negedge clk);
    add(FUNC_CONVERT, 8'h00, 8'h00, 32'hffff_ffff);
    settle();
    write_reg(REG_CHANNEL_BITS, CFG_W'(16'h1357));
    write_reg(REG_CHANNEL_SHIFTS, {5'd24, 5'd16, 5'd8, 5'd0});
    @(negedge clk);
    add(FUNC_CONVERT, 8'h00, 8'h00, 32'h8040_c0ff);
    settle();
    write_reg(REG_PIXEL_BYTES, CFG_W'(3'd2));
    @(negedge clk);
    add(FUNC_CONVERT, 8'h00, 8'h00, 32'h00ff_00ff);
    settle();

    for (int p = 0; p < 8; p++) begin
      gaps_on = (p != 3);
      random_setup();
      random_items(45);
      settle();
    end

    if (errors == 0 && due_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
